@@ design/ips_psp_pkg.sv @@
// ----------------------------------------------------------------------------
// IPS patch stream parser package
// Phase and result codes, parser state and result records, marker lookup.
// ----------------------------------------------------------------------------
package ips_psp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_MARKER  = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_RUN     = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_WRITE     = 3'd0,
		K_FILL      = 3'd1,
		K_END       = 3'd2,
		K_BADMARK   = 3'd3,
		K_TRUNC_RUN = 3'd4,
		K_TRUNC_PAY = 3'd5
	} kind_t;

	localparam int unsigned ADDR_W     = 25;
	localparam int unsigned OFFSET_W   = 24;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned POS_W      = 3;
	localparam logic [POS_W-1:0] MARKER_LEN = 3'd5;
	localparam logic [POS_W-1:0] HDR_LAST   = 3'd4;
	localparam logic [POS_W-1:0] RUN_FILL   = 3'd2;

	typedef struct packed {
		phase_t                phase;
		logic [POS_W-1:0]      pos;
		logic [OFFSET_W-1:0]   offset;
		logic [LEN_W-1:0]      length;
		logic [ADDR_W-1:0]     waddr;
		logic [LEN_W-1:0]      run_count;
	} parse_state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ADDR_W-1:0]     address;
		logic [7:0]            data;
		logic [LEN_W-1:0]      count;
		logic                  fin;
	} result_t;

	// "PATCH"
	function automatic logic [7:0] marker_byte(input logic [POS_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h50;
			3'd1:    b = 8'h41;
			3'd2:    b = 8'h54;
			3'd3:    b = 8'h43;
			3'd4:    b = 8'h48;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ design/ips_psp_step.sv @@
// ----------------------------------------------------------------------------
// IPS patch stream parser step logic
// Next parser state and optional result for one stream byte.
// ----------------------------------------------------------------------------
module ips_psp_step (
	input  ips_psp_pkg::parse_state_t cur,
	input  logic                      check_marker,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	output ips_psp_pkg::parse_state_t nxt,
	output logic                      emit,
	output ips_psp_pkg::result_t      res
);
	import ips_psp_pkg::*;

	phase_t               ph;
	logic [POS_W-1:0]     pos;
	logic [OFFSET_W-1:0]  new_off;
	logic [LEN_W-1:0]     new_len;
	logic [LEN_W-1:0]     new_rc;
	logic [LEN_W-1:0]     dec_len;

	always_comb begin
		nxt     = cur;
		emit    = 1'b0;
		res     = '{kind: K_END, address: '0, data: '0, count: '0, fin: 1'b1};
		ph      = cur.phase;
		pos     = cur.pos;
		new_off = cur.offset;
		new_len = cur.length;
		new_rc  = cur.run_count;
		dec_len = (cur.length != '0) ? cur.length - LEN_W'(1) : '0;

		// start phase is picked on the first beat of each stream
		if (ph == PH_IDLE) begin
			ph  = check_marker ? PH_MARKER : PH_HEADER;
			pos = '0;
		end
		nxt.phase = ph;
		nxt.pos   = pos;

		unique case (ph)
			PH_MARKER: begin
				if (pos >= MARKER_LEN || in_byte != marker_byte(pos)) begin
					emit     = 1'b1;
					res.kind = K_BADMARK;
					nxt.pos  = '0;
					nxt.phase = in_last ? PH_IDLE : PH_SKIP;
				end else if (pos == MARKER_LEN - POS_W'(1)) begin
					nxt.pos   = '0;
					nxt.phase = in_last ? PH_IDLE : PH_HEADER;
					emit      = in_last;
					res.kind  = K_END;
				end else begin
					nxt.pos = pos + POS_W'(1);
					if (in_last) begin
						emit      = 1'b1;
						res.kind  = K_BADMARK;
						nxt.phase = PH_IDLE;
						nxt.pos   = '0;
					end
				end
			end
			PH_HEADER: begin
				unique case (pos)
					3'd0:    new_off = {in_byte, 16'h0000};
					3'd1:    new_off = {cur.offset[23:16], in_byte, cur.offset[7:0]};
					3'd2:    new_off = {cur.offset[23:8], in_byte};
					3'd3:    new_len = {in_byte, 8'h00};
					default: new_len = {cur.length[15:8], in_byte};
				endcase
				nxt.offset = new_off;
				nxt.length = new_len;
				if (pos < HDR_LAST) begin
					nxt.pos = pos + POS_W'(1);
					if (in_last) begin
						emit      = 1'b1;
						res.kind  = K_END;
						nxt.phase = PH_IDLE;
						nxt.pos   = '0;
					end
				end else begin
					nxt.pos = '0;
					if (new_len != '0) begin
						nxt.phase = in_last ? PH_IDLE : PH_PAYLOAD;
						nxt.waddr = {1'b0, new_off};
						emit      = in_last;
						res.kind  = K_TRUNC_PAY;
					end else begin
						nxt.phase = in_last ? PH_IDLE : PH_RUN;
						emit      = in_last;
						res.kind  = K_TRUNC_RUN;
					end
				end
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				if (in_last && cur.length > LEN_W'(1)) begin
					res.kind  = K_TRUNC_PAY;
					nxt.phase = PH_IDLE;
					nxt.pos   = '0;
				end else begin
					res.kind    = K_WRITE;
					res.address = cur.waddr;
					res.data    = in_byte;
					res.count   = LEN_W'(1);
					res.fin     = in_last;
					nxt.waddr   = cur.waddr + ADDR_W'(1);
					nxt.length  = dec_len;
					if (dec_len == '0) begin
						nxt.phase = PH_HEADER;
						nxt.pos   = '0;
					end
					if (in_last) begin
						nxt.phase = PH_IDLE;
						nxt.pos   = '0;
					end
				end
			end
			PH_RUN: begin
				if (pos == 3'd0)
					new_rc = {in_byte, 8'h00};
				else if (pos == 3'd1)
					new_rc = {cur.run_count[15:8], in_byte};
				nxt.run_count = new_rc;
				if (pos < RUN_FILL) begin
					nxt.pos = pos + POS_W'(1);
					if (in_last) begin
						emit      = 1'b1;
						res.kind  = K_TRUNC_RUN;
						nxt.phase = PH_IDLE;
						nxt.pos   = '0;
					end
				end else begin
					nxt.pos   = '0;
					nxt.phase = in_last ? PH_IDLE : PH_HEADER;
					if (new_rc == '0) begin
						// empty run: nothing unless it closes the stream
						emit     = in_last;
						res.kind = K_END;
					end else begin
						emit        = 1'b1;
						res.kind    = K_FILL;
						res.address = {1'b0, cur.offset};
						res.data    = in_byte;
						res.count   = new_rc;
						res.fin     = in_last;
					end
				end
			end
			PH_SKIP: begin
				if (in_last) begin
					nxt.phase = PH_IDLE;
					nxt.pos   = '0;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
				nxt.pos   = '0;
			end
		endcase
	end

endmodule

@@ design/ips_patch_stream_parser.sv @@
// ----------------------------------------------------------------------------
// IPS patch stream parser
// Turns an IPS patch byte stream into byte-write and fill-run commands and status results.
// ----------------------------------------------------------------------------
// One patch byte is taken per cycle, sustained, as long as each result is
// taken in the cycle it appears. A result held by out_ready low stalls the
// parse stage, and the input register, if empty, takes one more byte before
// in_ready drops. Each byte passes an input register, then combinational
// parse logic that updates the parser state and loads the result register
// when the parse stage advances. The rate is set by the parser state update
// loop. Each byte yields at most one result beat. check_marker is sampled on
// the first byte of each stream; write it only while the parser is idle.
module ips_patch_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_kind,
	output logic [24:0] out_address,
	output logic [7:0]  out_data,
	output logic [15:0] out_count,
	output logic        out_end
);
	import ips_psp_pkg::*;

	logic         check_marker_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         adv_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         emit;
	result_t      res;
	logic         out_valid_q;
	result_t      res_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_marker_q <= 1'b1;
		end else if (cfg_write_en) begin
			check_marker_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	ips_psp_step u_step (
		.cur          (state_q),
		.check_marker (check_marker_q),
		.in_byte      (byte_s1),
		.in_last      (last_s1),
		.nxt          (state_nxt),
		.emit         (emit),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, pos: '0, offset: '0, length: '0,
				waddr: '0, run_count: '0};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = res_q.kind;
	assign out_address = res_q.address;
	assign out_data    = res_q.data;
	assign out_count   = res_q.count;
	assign out_end     = res_q.fin;

`ifndef SYNTHESIS
	// a stalled first-stage beat is neither lost nor changed
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage beat dropped or changed while stalled");

	// status results always close the stream
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind != K_WRITE && res_q.kind != K_FILL |-> res_q.fin)
		else $error("status result without end flag");

	// byte writes carry a count of one, fills a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.kind == K_WRITE || res_q.kind == K_FILL)
		|-> res_q.count != '0 && (res_q.kind != K_WRITE || res_q.count == 16'd1))
		else $error("bad count on write or fill");

	// byte position stays inside the field of the current phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_HEADER |-> state_q.pos <= HDR_LAST) and
		(state_q.phase == PH_RUN |-> state_q.pos <= RUN_FILL) and
		(state_q.phase == PH_MARKER |-> state_q.pos < MARKER_LEN))
		else $error("byte position out of range for phase");

	// payload phase never holds an exhausted length
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_PAYLOAD |-> state_q.length != '0)
		else $error("payload phase with zero length");
`endif

endmodule
